### rtl/piwc_pkg.sv
package piwc_pkg;

  // Width of a hash index; it covers 1 through 1024.
  localparam int IDX_W = 11;

  // Width of the part of the word that the report shows (bits 31 to 5).
  localparam int REPORT_W = 27;

  // Opcode field (bits 31 to 22) of a privileged instruction.
  localparam logic [9:0] PRIV_OPCODE = 10'd852;

  // Reset value of the index limit register.
  localparam logic [IDX_W-1:0] LIMIT_RESET = 11'd1000;

  typedef enum logic [2:0] {
    VERDICT_NOT_PRIV = 3'd0,
    VERDICT_GOOD     = 3'd1,
    VERDICT_BAD      = 3'd2,
    VERDICT_SKIPPED  = 3'd3,
    VERDICT_INSERTED = 3'd4,
    VERDICT_DROPPED  = 3'd5
  } verdict_t;

  typedef enum logic {
    ACTION_INSERT = 1'b0,
    ACTION_SCAN   = 1'b1
  } action_t;

  // What the decoder tells the pipeline about one instruction word.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             priv;
    logic             outside;
  } decode_t;

endpackage

### rtl/piwc_decode.sv
module piwc_decode #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic [31:0]                 word,
  input  logic [piwc_pkg::IDX_W-1:0]  limit,
  output piwc_pkg::decode_t           dec
);
  import piwc_pkg::*;

  localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(TABLE_DEPTH);

  logic [IDX_W-1:0] idx;

  // Hash index: bits 21..12 folded with bits 11..5, plus one.
  assign idx = {1'b0, word[21:12] ^ {3'b000, word[11:5]}} + 11'd1;

  // A word is privileged on its opcode field with bit 20 or bit 19 set.
  assign dec.priv = (word[31:22] == PRIV_OPCODE) && (word[20] || word[19]);

  // An index is outside at or above the limit or beyond the table.
  assign dec.outside = (idx >= limit) || ({1'b0, idx} >= DEPTH_V);

  assign dec.idx = idx;

endmodule

### rtl/privileged_instruction_whitelist_check_top.sv
// Privileged instruction whitelist check. Each input beat carries an
// instruction word and an action: insert stores the word in a whitelist
// table at its hash index unless the index is outside, scan classifies the
// word and, when it is privileged and not outside, checks it against the
// table. It takes one beat per cycle unless clearing or a stalled output
// holds it, and returns exactly one result beat per input beat, through the
// judge stage and then the output register; the single table port serves
// either the write of an insert or the read of a scan in the cycle the beat
// is accepted, and the registered read data is judged in the next cycle.
// After reset in_ready stays low while the table is cleared, one entry per
// cycle; cfg writes are taken at any time. Each entry keeps only a nonzero
// flag and the top MATCH_BITS bits of the stored word.
module privileged_instruction_whitelist_check_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MATCH_BITS  = 27
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [31:0]                   in_instruction_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_verdict,
  output logic [piwc_pkg::IDX_W-1:0]    out_table_index,
  output logic [piwc_pkg::REPORT_W-1:0] out_reported_bits,
  input  logic                          cfg_wr_en,
  input  logic [piwc_pkg::IDX_W-1:0]    cfg_wr_data
);
  import piwc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = MATCH_BITS + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  // Configuration register.
  logic [IDX_W-1:0] limit_r;

  // Clearing pass.
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Table memory and its registered read data.
  logic [EW-1:0] whitelist_mem_r [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;

  // Judge stage.
  logic                  s1_valid_r, s1_valid_nxt;
  action_t               s1_action_r;
  logic                  s1_priv_r;
  logic                  s1_outside_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [REPORT_W-1:0]   s1_bits_r;
  logic [MATCH_BITS-1:0] s1_key_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  verdict_t            out_verdict_r, verdict_nxt;
  logic [IDX_W-1:0]    out_index_r;
  logic [REPORT_W-1:0] out_bits_r;

  decode_t dec;
  logic    in_fire, advance, entry_match;

  piwc_decode #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_decode (
    .word  (in_instruction_word),
    .limit (limit_r),
    .dec   (dec)
  );

  // Handshake: the judge stage moves on when the output register is free.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !clr_busy_r && (!s1_valid_r || advance);
  assign in_fire  = in_valid && in_ready;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Clearing pass over every entry after reset.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Single table port: clear writes, insert writes, scan reads.
  // Only one beat is accepted per cycle, so a scan always sees earlier inserts.
  assign mem_addr  = clr_busy_r ? clr_addr_r : dec.idx[AW-1:0];
  assign mem_we    = clr_busy_r ||
                     (in_fire && (in_action == ACTION_INSERT) && !dec.outside);
  assign mem_re    = in_fire && (in_action == ACTION_SCAN) && dec.priv && !dec.outside;
  assign mem_wdata = clr_busy_r ? '0 :
                     {|in_instruction_word, in_instruction_word[31 -: MATCH_BITS]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      whitelist_mem_r[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= whitelist_mem_r[mem_addr];
    end
  end

  // Judge stage registers.
  assign s1_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r  <= action_t'(in_action);
      s1_priv_r    <= dec.priv;
      s1_outside_r <= dec.outside;
      s1_idx_r     <= dec.idx;
      s1_bits_r    <= in_instruction_word[31:5];
      s1_key_r     <= in_instruction_word[31 -: MATCH_BITS];
    end
  end

  // Verdict from the stored entry and the decoded flags.
  assign entry_match = rd_data_r[EW-1] && (rd_data_r[MATCH_BITS-1:0] == s1_key_r);

  always_comb begin
    if (s1_action_r == ACTION_INSERT) begin
      verdict_nxt = s1_outside_r ? VERDICT_DROPPED : VERDICT_INSERTED;
    end else if (!s1_priv_r) begin
      verdict_nxt = VERDICT_NOT_PRIV;
    end else if (s1_outside_r) begin
      verdict_nxt = VERDICT_SKIPPED;
    end else begin
      verdict_nxt = entry_match ? VERDICT_GOOD : VERDICT_BAD;
    end
  end

  // Output register.
  assign out_valid_nxt = (s1_valid_r && advance) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_verdict_r <= verdict_nxt;
      out_index_r   <= s1_idx_r;
      out_bits_r    <= s1_bits_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_verdict_r;
  assign out_table_index   = out_index_r;
  assign out_reported_bits = out_bits_r;

endmodule

### rtl/piwc_checker.sv
module piwc_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    out_verdict,
  input logic [piwc_pkg::IDX_W-1:0]    out_table_index,
  input logic [piwc_pkg::REPORT_W-1:0] out_reported_bits
);
  import piwc_pkg::*;

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
      $stable(out_table_index) && $stable(out_reported_bits))
    else $error("result beat changed while stalled");

  // Only defined verdict codes appear.
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_NOT_PRIV) || (out_verdict == VERDICT_GOOD) ||
      (out_verdict == VERDICT_BAD) || (out_verdict == VERDICT_SKIPPED) ||
      (out_verdict == VERDICT_INSERTED) || (out_verdict == VERDICT_DROPPED))
    else $error("undefined verdict code");

  // The hash index always lies in 1 through 1024.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_table_index != 11'd0) && (out_table_index <= 11'd1024))
    else $error("hash index out of range");

  // Good, bad and skipped are given only for privileged words.
  a_priv_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_verdict == VERDICT_GOOD) || (out_verdict == VERDICT_BAD) ||
      (out_verdict == VERDICT_SKIPPED)) |->
      (out_reported_bits[26:17] == PRIV_OPCODE) && (out_reported_bits[15:14] != 2'b00))
    else $error("privileged verdict for a non-privileged word");

  // The table clearing pass blocks input right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("input taken during clearing pass");

endmodule

bind privileged_instruction_whitelist_check_top piwc_props u_piwc_props (.*);

### tb/piwc_checker.sv
// Passive checker for the privileged instruction whitelist check block.
// It keeps its own copy of the whitelist table and of index_limit. It
// predicts the result of every accepted input beat and compares each result
// beat, in order, with the oldest prediction.
module piwc_checker
  import piwc_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int MATCH_BITS  = 27
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_action,
  input  logic [31:0]         in_instruction_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [2:0]          out_verdict,
  input  logic [IDX_W-1:0]    out_table_index,
  input  logic [REPORT_W-1:0] out_reported_bits,
  input  logic                cfg_wr_en,
  input  logic [IDX_W-1:0]    cfg_wr_data,
  output int                  err_count,
  output int                  pending_count,
  output int                  result_count
);

  typedef struct {
    verdict_t            verdict;
    logic [IDX_W-1:0]    table_index;
    logic [REPORT_W-1:0] reported_bits;
  } word_report_t;

  logic [31:0]      whitelist_copy [TABLE_DEPTH];
  logic [IDX_W-1:0] limit_copy;
  word_report_t     expected_reports [$];

  initial begin
    err_count     = 0;
    pending_count = 0;
    result_count  = 0;
  end

  // Works out the report for one word and applies an insert to the table copy.
  function automatic word_report_t judge_word(input logic act, input logic [31:0] w);
    word_report_t     rep;
    logic [IDX_W-1:0] idx;
    logic             outside;
    logic             priv;
    logic [31:0]      entry;
    idx = {1'b0, w[21:12] ^ {3'b000, w[11:5]}} + 1'b1;
    outside = (idx >= limit_copy) || (idx >= TABLE_DEPTH);
    priv = (w[31:22] == PRIV_OPCODE) && (w[20] || w[19]);
    rep.table_index   = idx;
    rep.reported_bits = w[31:5];
    if (act == ACTION_INSERT) begin
      if (outside) begin
        rep.verdict = VERDICT_DROPPED;
      end else begin
        whitelist_copy[idx] = w;
        rep.verdict = VERDICT_INSERTED;
      end
    end else if (!priv) begin
      rep.verdict = VERDICT_NOT_PRIV;
    end else if (outside) begin
      rep.verdict = VERDICT_SKIPPED;
    end else begin
      entry = whitelist_copy[idx];
      // Only the top bits of a stored word take part in the match.
      if (entry != 32'd0 && entry[31 -: MATCH_BITS] == w[31 -: MATCH_BITS]) begin
        rep.verdict = VERDICT_GOOD;
      end else begin
        rep.verdict = VERDICT_BAD;
      end
    end
    return rep;
  endfunction

  // Track reset, configuration, accepted inputs and result beats.
  always @(posedge clk) begin : watch_channels
    word_report_t want;
    if (!rst_n) begin
      for (int k = 0; k < TABLE_DEPTH; k++) whitelist_copy[k] = 32'd0;
      limit_copy = LIMIT_RESET;
      expected_reports.delete();
    end else begin
      // Compare a result beat with the oldest prediction.
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_reports.size() == 0) begin
          $error("result beat with no prediction waiting: verdict %0d index %0d",
                 out_verdict, out_table_index);
          err_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict mismatch: expected %0d, actual %0d", want.verdict, out_verdict);
            err_count++;
          end
          if (out_table_index !== want.table_index) begin
            $error("table_index mismatch: expected %0d, actual %0d",
                   want.table_index, out_table_index);
            err_count++;
          end
          if (out_reported_bits !== want.reported_bits) begin
            $error("reported_bits mismatch: expected %h, actual %h",
                   want.reported_bits, out_reported_bits);
            err_count++;
          end
        end
      end
      // Predict the result of an accepted input beat.
      if (in_valid && in_ready) begin
        expected_reports.push_back(judge_word(in_action, in_instruction_word));
      end
      if (cfg_wr_en) begin
        limit_copy = cfg_wr_data;
      end
    end
    pending_count = expected_reports.size();
  end

endmodule

### tb/tb.sv
// Stimulus and verdict for the privileged instruction whitelist check block.
module tb;
  import piwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BEATS    = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_action = 1'b0;
  logic [31:0]         in_instruction_word = 32'd0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_verdict;
  logic [IDX_W-1:0]    out_table_index;
  logic [REPORT_W-1:0] out_reported_bits;
  logic                cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]    cfg_wr_data = '0;

  int          err_count;
  int          pending_count;
  int          result_count;
  int          snd_idle_pct = 10;
  int          rcv_idle_pct = 57;
  int          beats_sent = 0;
  int          limit_writes = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  logic [31:0] word_pool [$];

  privileged_instruction_whitelist_check_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_verdict         (out_verdict),
    .out_table_index     (out_table_index),
    .out_reported_bits   (out_reported_bits),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  piwc_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_verdict         (out_verdict),
    .out_table_index     (out_table_index),
    .out_reported_bits   (out_reported_bits),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .err_count           (err_count),
    .pending_count       (pending_count),
    .result_count        (result_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random, plus one long hold-off that fills the block.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // The run ends if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] pack_word(input logic [9:0] opc, input logic [9:0] hi,
                                            input logic [6:0] lo, input logic [4:0] tail);
    return {opc, hi, lo, tail};
  endfunction

  // Flips one bit of each hash half at the same position: same index,
  // different top bits, privilege unchanged.
  function automatic logic [31:0] twin_word(input logic [31:0] w, input int k);
    return w ^ (32'd1 << (12 + k)) ^ (32'd1 << (5 + k));
  endfunction

  // Forces a random word into the privileged opcode pattern.
  function automatic logic [31:0] priv_form(input logic [31:0] r);
    logic [31:0] w;
    w = r;
    w[31:22] = PRIV_OPCODE;
    if (w[20:19] == 2'b00) begin
      w[20:19] = r[0] ? 2'b10 : 2'b01;
    end
    return w;
  endfunction

  // Offers one beat, with random idle cycles in front, and waits until it
  // is accepted. Called and returns at a falling edge.
  task automatic send_beat(input action_t act, input logic [31:0] word);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= act;
    in_instruction_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted result has arrived.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes index_limit once the block is idle.
  task automatic set_limit(input logic [IDX_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_writes++;
    @(negedge clk);
  endtask

  // Mostly inserts followed by rescans of known words, some noise.
  task automatic send_random_beat;
    int          pick;
    logic [31:0] w;
    pick = $urandom_range(99);
    w = $urandom();
    if (pick < 25) begin
      w = priv_form(w);
      word_pool.push_back(w);
      send_beat(ACTION_INSERT, w);
    end else if (pick < 35) begin
      word_pool.push_back(w);
      send_beat(ACTION_INSERT, w);
    end else if (pick < 37) begin
      send_beat(ACTION_INSERT, 32'd0);
    end else if (pick < 70 && word_pool.size() > 0) begin
      w = word_pool[$urandom_range(word_pool.size() - 1)];
      if (pick < 55) begin
        w[4:0] = 5'($urandom());
      end else begin
        w = twin_word(w, $urandom_range(6));
      end
      send_beat(ACTION_SCAN, w);
    end else if (pick < 85) begin
      send_beat(ACTION_SCAN, priv_form(w));
    end else begin
      send_beat(ACTION_SCAN, w);
    end
    if (word_pool.size() > 32) begin
      void'(word_pool.pop_front());
    end
  endtask

  initial begin
    logic [31:0]      wa;
    logic [31:0]      wb;
    logic [31:0]      wc;
    logic [31:0]      w_top;
    logic [31:0]      w_999;
    logic [31:0]      w_1000;
    logic [31:0]      w_1023;
    logic [IDX_W-1:0] phase_limit [6];

    wa     = pack_word(PRIV_OPCODE, 10'h080, 7'h00, 5'h00);
    wb     = pack_word(PRIV_OPCODE, 10'h100, 7'h15, 5'h00);
    wc     = pack_word(PRIV_OPCODE, 10'h180, 7'h7F, 5'h1F);
    w_top  = pack_word(PRIV_OPCODE, 10'h3FF, 7'h00, 5'h00);
    w_999  = pack_word(PRIV_OPCODE, 10'h380, 7'h66, 5'h00);
    w_1000 = pack_word(PRIV_OPCODE, 10'h380, 7'h67, 5'h00);
    w_1023 = pack_word(PRIV_OPCODE, 10'h3FF, 7'h01, 5'h00);
    phase_limit = '{11'd1024, 11'd1, 11'd600, 11'd0, 11'd2047, 11'd1000};
    phase_limit[3] = 11'($urandom_range(2047));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset limit.
    set_limit(LIMIT_RESET);
    send_beat(ACTION_SCAN, wa);                  // empty entry gives bad
    send_beat(ACTION_INSERT, wa);
    send_beat(ACTION_SCAN, wa | 32'h1F);         // low five bits are ignored
    send_beat(ACTION_SCAN, twin_word(wa, 3));    // same index, other top bits
    send_beat(ACTION_INSERT, wb);
    send_beat(ACTION_SCAN, wb);
    send_beat(ACTION_SCAN, wc);
    send_beat(ACTION_INSERT, wc);
    send_beat(ACTION_SCAN, wc);
    // Words that are not privileged.
    send_beat(ACTION_SCAN, pack_word(10'd851, 10'h180, 7'h00, 5'h00));
    send_beat(ACTION_SCAN, pack_word(PRIV_OPCODE, 10'h27F, 7'h2A, 5'h00));
    send_beat(ACTION_SCAN, 32'd0);
    send_beat(ACTION_SCAN, 32'hFFFF_FFFF);
    send_beat(ACTION_INSERT, 32'hFFFF_FFFF);
    send_beat(ACTION_INSERT, 32'd0);             // a stored zero is an empty entry
    // Indices at the top of the range and around the limit.
    send_beat(ACTION_INSERT, w_top);
    send_beat(ACTION_SCAN, w_top);
    send_beat(ACTION_INSERT, w_999);
    send_beat(ACTION_SCAN, w_999);
    send_beat(ACTION_INSERT, w_1000);
    send_beat(ACTION_SCAN, w_1000);
    // Overwrite of an existing entry.
    send_beat(ACTION_INSERT, twin_word(wa, 0));
    send_beat(ACTION_SCAN, wa);
    send_beat(ACTION_SCAN, twin_word(wa, 0));

    // A zero limit puts every index outside.
    set_limit(11'd0);
    send_beat(ACTION_INSERT, wa);
    send_beat(ACTION_SCAN, wa);

    // The largest limit: index 1024 is still beyond the table.
    set_limit(11'd2047);
    send_beat(ACTION_INSERT, w_top);
    send_beat(ACTION_SCAN, w_top);
    send_beat(ACTION_INSERT, w_1023);
    send_beat(ACTION_SCAN, w_1023);

    // Random phases, each under its own limit; the idle pattern changes every two phases.
    for (int ph = 0; ph < 6; ph++) begin
      set_limit(phase_limit[ph]);
      if (ph < 2) begin
        snd_idle_pct = 10;
        rcv_idle_pct = 57;
      end else if (ph < 4) begin
        snd_idle_pct = 57;
        rcv_idle_pct = 10;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (ph == 0) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_random_beat();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Summary: %0d input beats and %0d result beats checked under %0d limit settings,",
             beats_sent, result_count, limit_writes);
    $display("including a zero limit, the full register range and a long output stall.");
    if (err_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/piwc_pkg.sv
rtl/piwc_decode.sv
rtl/privileged_instruction_whitelist_check_top.sv
rtl/piwc_checker.sv
tb/piwc_checker.sv
tb/tb.sv
